FILE: src/bwb_pkg.sv
package bwb_pkg;

   localparam int ADDR_W = 32;
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 4;

   localparam logic [CSR_W-1:0] CSR_ENTRY_BYTES_RESET = 4'd8;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] data_byte;
      logic              ends_write;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] bus_address;
      logic [BYTE_W-1:0] bus_byte;
      logic              last_of_run;
   } rsp_payload_type;

endpackage

FILE: src/bwb_req_if.sv
interface bwb_req_if import bwb_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/bwb_rsp_if.sv
interface bwb_rsp_if import bwb_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/byte_write_buffer_fifo.sv
// A byte write that fits an open or free entry is stored as it is taken; no item goes out.
// A flush reads the oldest entry's header (META, LOAD), then each byte in turn: a storage
// read (READ), then a move into the free output register (SEND); a further entry of a drain
// starts again with a header read. The write that forced the flush is then stored (WRITE).
// Throughput: 1 byte write per cycle while no flush runs.
// Reset: sync, active high; clears pointers, counts and output valid; memories not cleared.
module byte_write_buffer_fifo import bwb_pkg::*; #(
   parameter int NUM_ENTRIES     = 8,
   parameter int MAX_ENTRY_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   bwb_req_if.sink          req_chan,
   bwb_rsp_if.source        rsp_chan,
   input  logic             csr_write_en,
   input  logic [CSR_W-1:0] csr_write_data
);

   // ------------------------------------------------------------------
   // Derived widths
   // ------------------------------------------------------------------
   localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(NUM_ENTRIES + 1);
   localparam int FILL_W    = $clog2(MAX_ENTRY_BYTES + 1);
   localparam int STO_DEPTH = NUM_ENTRIES * MAX_ENTRY_BYTES;
   localparam int STO_W     = (STO_DEPTH > 1) ? $clog2(STO_DEPTH) : 1;
   localparam int CMP_W     = (FILL_W > CSR_W) ? FILL_W : CSR_W;

   // ------------------------------------------------------------------
   // Flush sequencer states
   //   IDLE : takes items
   //   META : header read of the oldest entry in flight
   //   LOAD : header captured, byte counter set up
   //   READ : storage read of the current byte in flight
   //   SEND : byte moves into the output register when it is free
   //   WRITE: stores the byte whose write forced the flush
   // ------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_META,
      ST_LOAD,
      ST_READ,
      ST_SEND,
      ST_WRITE
   } state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      ring_next = (i == IDX_W'(NUM_ENTRIES - 1)) ? '0 : i + 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Memories: entry header (start address, fill) and byte storage
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0] entry_addr_mem [NUM_ENTRIES];
   logic [FILL_W-1:0] entry_fill_mem [NUM_ENTRIES];
   logic [BYTE_W-1:0] storage_mem    [STO_DEPTH];

   logic              addr_we;
   logic [IDX_W-1:0]  addr_waddr;
   logic [ADDR_W-1:0] addr_wdata;
   logic              fill_we;
   logic [IDX_W-1:0]  fill_waddr;
   logic [FILL_W-1:0] fill_wdata;
   logic              sto_we;
   logic [STO_W-1:0]  sto_waddr;
   logic [BYTE_W-1:0] sto_wdata;
   logic [STO_W-1:0]  sto_raddr;

   logic [ADDR_W-1:0] addr_rd_ff;
   logic [FILL_W-1:0] fill_rd_ff;
   logic [BYTE_W-1:0] sto_rd_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  entry_bytes_ff, entry_bytes_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  open_idx_ff, open_idx_in;
   logic [FILL_W-1:0] open_fill_ff, open_fill_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [ADDR_W-1:0] next_addr_ff, next_addr_in;
   logic              write_open_ff, write_open_in;
   logic              drain_ff, drain_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic              pend_ends_ff, pend_ends_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [FILL_W-1:0] cur_cnt_ff, cur_cnt_in;
   logic [FILL_W-1:0] k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------
   logic [CMP_W-1:0]  csr_ext;
   logic [CMP_W-1:0]  lim_ext;
   logic [FILL_W-1:0] lim_fill;
   logic              req_take;
   logic              need_new;
   logic [ADDR_W-1:0] start_addr;
   logic              out_free;
   logic [FILL_W-1:0] k_next;
   logic              entry_end;
   logic              run_last;

   // byte store, shared by the direct path and the held write
   logic              wr_go;
   logic              wr_new;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_byte;
   logic              wr_ends;
   logic [IDX_W-1:0]  wr_idx;
   logic [FILL_W-1:0] wr_fill;

   // entry size clamp: 0 acts as 1, above the maximum acts as the maximum
   assign csr_ext  = CMP_W'(entry_bytes_ff);
   assign lim_ext  = (entry_bytes_ff == '0) ? CMP_W'(1) :
                     (csr_ext > CMP_W'(MAX_ENTRY_BYTES)) ? CMP_W'(MAX_ENTRY_BYTES) : csr_ext;
   assign lim_fill = lim_ext[FILL_W-1:0];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && (state_ff == ST_IDLE);

   assign need_new   = !write_open_ff || (used_ff == '0) || (open_fill_ff >= lim_fill);
   assign start_addr = write_open_ff ? next_addr_ff : req_chan.payload.address;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign k_next    = k_ff + 1'b1;
   assign entry_end = (k_next == cur_cnt_ff);
   // a drain runs until the last entry; a forced flush ends with its one entry
   assign run_last  = entry_end && (!drain_ff || (used_ff == CNT_W'(1)));

   assign sto_raddr = STO_W'(int'(tail_ff) * MAX_ENTRY_BYTES + int'(k_ff));

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      entry_bytes_in = csr_write_en ? csr_write_data : entry_bytes_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      open_idx_in    = open_idx_ff;
      open_fill_in   = open_fill_ff;
      used_in        = used_ff;
      next_addr_in   = next_addr_ff;
      write_open_in  = write_open_ff;
      drain_in       = drain_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      pend_byte_in   = pend_byte_ff;
      pend_ends_in   = pend_ends_ff;
      cur_addr_in    = cur_addr_ff;
      cur_cnt_in     = cur_cnt_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;

      wr_go   = 1'b0;
      wr_new  = 1'b0;
      wr_addr = start_addr;
      wr_byte = req_chan.payload.data_byte;
      wr_ends = req_chan.payload.ends_write;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.payload.req_type == REQ_DRAIN) begin
                  // empty drain: nothing to send
                  if (used_ff != '0) begin
                     drain_in = 1'b1;
                     pend_in  = 1'b0;
                     state_in = ST_META;
                  end
               end else if (need_new && (used_ff == CNT_W'(NUM_ENTRIES))) begin
                  // ring full: hold the byte, flush the oldest entry first
                  drain_in     = 1'b0;
                  pend_in      = 1'b1;
                  pend_addr_in = start_addr;
                  pend_byte_in = req_chan.payload.data_byte;
                  pend_ends_in = req_chan.payload.ends_write;
                  state_in     = ST_META;
               end else begin
                  wr_go  = 1'b1;
                  wr_new = need_new;
               end
            end
         end
         ST_META: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cur_addr_in = addr_rd_ff;
            cur_cnt_in  = fill_rd_ff;
            k_in        = '0;
            state_in    = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.bus_address = cur_addr_ff;
               rsp_data_in.bus_byte    = sto_rd_ff;
               rsp_data_in.last_of_run = run_last;
               k_in                    = k_next;
               cur_addr_in             = cur_addr_ff + 1'b1;
               if (entry_end) begin
                  tail_in = ring_next(tail_ff);
                  used_in = used_ff - 1'b1;
                  if (!run_last) begin
                     state_in = ST_META;
                  end else if (pend_ff) begin
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_WRITE: begin
            wr_go    = 1'b1;
            wr_new   = 1'b1;
            wr_addr  = pend_addr_ff;
            wr_byte  = pend_byte_ff;
            wr_ends  = pend_ends_ff;
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store one byte, opening a new entry at the head if asked
      wr_idx     = wr_new ? head_ff : open_idx_ff;
      wr_fill    = wr_new ? '0 : open_fill_ff;
      sto_we     = wr_go;
      sto_waddr  = STO_W'(int'(wr_idx) * MAX_ENTRY_BYTES + int'(wr_fill));
      sto_wdata  = wr_byte;
      fill_we    = wr_go;
      fill_waddr = wr_idx;
      fill_wdata = wr_fill + 1'b1;
      addr_we    = wr_go && wr_new;
      addr_waddr = head_ff;
      addr_wdata = wr_addr;
      if (wr_go) begin
         open_fill_in  = wr_fill + 1'b1;
         next_addr_in  = wr_addr + 1'b1;
         write_open_in = !wr_ends;
         if (wr_new) begin
            open_idx_in = head_ff;
            head_in     = ring_next(head_ff);
            used_in     = used_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Control and payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_bytes_ff <= CSR_ENTRY_BYTES_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         used_ff        <= '0;
         next_addr_ff   <= '0;
         write_open_ff  <= 1'b0;
         drain_ff       <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_bytes_ff <= entry_bytes_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         used_ff        <= used_in;
         next_addr_ff   <= next_addr_in;
         write_open_ff  <= write_open_in;
         drain_ff       <= drain_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      open_idx_ff  <= open_idx_in;
      open_fill_ff <= open_fill_in;
      pend_addr_ff <= pend_addr_in;
      pend_byte_ff <= pend_byte_in;
      pend_ends_ff <= pend_ends_in;
      cur_addr_ff  <= cur_addr_in;
      cur_cnt_ff   <= cur_cnt_in;
      k_ff         <= k_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Memories; reads always follow the oldest entry
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (addr_we) begin
         entry_addr_mem[addr_waddr] <= addr_wdata;
      end
      addr_rd_ff <= entry_addr_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         entry_fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= entry_fill_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (sto_we) begin
         storage_mem[sto_waddr] <= sto_wdata;
      end
      sto_rd_ff <= storage_mem[sto_raddr];
   end

endmodule

FILE: src/bwb_checker.sv
module bwb_checker import bwb_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // set once a run has given an item that is not its last
   logic in_run_ff, in_run_in;

   always_comb begin
      in_run_in = in_run_ff;
      if (rsp_valid && rsp_ready) begin
         in_run_in = !rsp_payload.last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else begin
         in_run_ff <= in_run_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      in_run_ff && !(rsp_valid && rsp_payload.last_of_run) |-> !(req_valid && req_ready))
      else $error("request taken in the middle of a flush run");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind byte_write_buffer_fifo bwb_checker u_bwb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

FILE: tb/byte_write_buffer_fifo_tb.sv
module byte_write_buffer_fifo_tb;
   import bwb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Ring geometry, matches the block's parameter defaults.
   localparam int NUM_ENT   = 8;
   localparam int MAX_BYTES = 8;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_en;
   logic [CSR_W-1:0] csr_write_data;

   bwb_req_if req_chan ();
   bwb_rsp_if rsp_chan ();

   byte_write_buffer_fifo u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Buffer predictor: a shadow copy of the ring, updated per accepted item.
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0] ent_addr [NUM_ENT];
   logic [BYTE_W-1:0] ent_data [NUM_ENT][MAX_BYTES];
   int unsigned       ent_fill [NUM_ENT];
   int unsigned       head_idx;
   int unsigned       tail_idx;
   int unsigned       used_cnt;
   logic [ADDR_W-1:0] next_addr;
   bit                write_open;
   logic [CSR_W-1:0]  entry_bytes_cfg;

   rsp_payload_type   flushed_bytes[$];        // bus writes of the item being predicted
   rsp_payload_type   expected_bus_writes[$];  // bus writes still owed by the block

   int errors;
   int items_sent;

   // Sender burst state and receiver hold-off control.
   bit sender_gaps_on;
   int burst_left;
   int hold_cycles;
   bit rsp_hold;

   // Oldest entry goes out byte by byte at ascending, wrapping addresses.
   function automatic void flush_oldest_entry();
      rsp_payload_type   w;
      logic [ADDR_W-1:0] a;
      a = ent_addr[tail_idx];
      for (int k = 0; k < int'(ent_fill[tail_idx]); k++) begin
         w.bus_address = a;
         w.bus_byte    = ent_data[tail_idx][k];
         w.last_of_run = 1'b0;
         flushed_bytes.push_back(w);
         a = a + 1'b1;
      end
      tail_idx = (tail_idx + 1) % NUM_ENT;
      if (used_cnt > 0) used_cnt--;
   endfunction

   function automatic void predict_bus_writes(req_payload_type item);
      int unsigned     lim;
      int unsigned     open_e;
      int unsigned     f;
      bit              need_new;
      rsp_payload_type w;
      flushed_bytes.delete();
      // out-of-range sizes are clamped
      if (entry_bytes_cfg == 0) lim = 1;
      else if (entry_bytes_cfg > MAX_BYTES) lim = MAX_BYTES;
      else lim = int'(entry_bytes_cfg);

      if (item.req_type == REQ_DRAIN) begin
         while (used_cnt > 0) flush_oldest_entry();
      end else begin
         open_e   = (head_idx == 0) ? NUM_ENT - 1 : head_idx - 1;
         need_new = !write_open || used_cnt == 0 || ent_fill[open_e] >= lim;
         if (need_new) begin
            if (!write_open) next_addr = item.address;
            // ring full: make room first
            if (used_cnt >= NUM_ENT) flush_oldest_entry();
            ent_addr[head_idx] = next_addr;
            ent_fill[head_idx] = 0;
            open_e             = head_idx;
            head_idx           = (head_idx + 1) % NUM_ENT;
            used_cnt++;
         end
         f = ent_fill[open_e];
         if (f < MAX_BYTES) begin
            ent_data[open_e][f] = item.data_byte;
            ent_fill[open_e]    = f + 1;
         end
         next_addr  = next_addr + 1'b1;
         write_open = !item.ends_write;
      end

      foreach (flushed_bytes[i]) begin
         w             = flushed_bytes[i];
         w.last_of_run = (i == flushed_bytes.size() - 1);
         expected_bus_writes.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender: one item per call, entered and left at a falling edge.
   // Bursts of random length, random gaps between them when enabled.
   // ------------------------------------------------------------------
   task automatic send_req(input logic              kind,
                           input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data,
                           input logic              ends);
      req_payload_type item;
      int              gap;
      item.req_type   = kind;
      item.address    = addr;
      item.data_byte  = data;
      item.ends_write = ends;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps_on && $urandom_range(0, 2) != 0) begin
            gap = $urandom_range(1, 6);
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_bus_writes(item);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_drain();
      send_req(REQ_DRAIN, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // Register write only with the block idle: input quiet, every bus write
   // back, then a margin for a write item still being stored.
   task automatic set_entry_bytes(input logic [CSR_W-1:0] value);
      req_chan.valid <= 1'b0;
      wait (expected_bus_writes.size() == 0);
      repeat (12) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      entry_bytes_cfg = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready pattern picks a new random mode when its counter runs out; hold-off wins.
   // ------------------------------------------------------------------
   always begin
      wait (hold_cycles != 0);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (hold_cycles) @(posedge clock);
      rsp_hold    = 1'b0;
      hold_cycles = 0;
   end

   int rx_mode;
   int rx_count;

   always @(negedge clock) begin
      if (rx_count == 0) begin
         rx_mode  = $urandom_range(0, 3);
         rx_count = 50;
      end
      rx_count--;
      if (reset || rsp_hold) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_chan.ready <= 1'b1;                          // no stalls
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= (rx_count % 3 == 0);    // ready when rx_count is a multiple of three
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Bus write checker: in order, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_bus_writes.size() == 0) begin
            $error("unexpected bus write: address %h byte %h last %b",
                   got.bus_address, got.bus_byte, got.last_of_run);
            errors++;
         end else begin
            want = expected_bus_writes.pop_front();
            if (got.bus_address !== want.bus_address) begin
               $error("bus_address expected %h actual %h", want.bus_address, got.bus_address);
               errors++;
            end
            if (got.bus_byte !== want.bus_byte) begin
               $error("bus_byte expected %h actual %h", want.bus_byte, got.bus_byte);
               errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run expected %b actual %b", want.last_of_run, got.last_of_run);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Write crossing the top of the address space, field extremes, then
   // a drain and a drain of an empty buffer.
   task automatic test_wrap_and_drain();
      send_req(REQ_WRITE, 32'hFFFF_FFFE, 8'h00, 1'b0);
      send_req(REQ_WRITE, 32'h0000_0000, 8'hFF, 1'b0);
      send_req(REQ_WRITE, 32'h1234_5678, 8'hA5, 1'b1);
      send_req(REQ_DRAIN, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      send_req(REQ_DRAIN, 32'h0000_0000, 8'h00, 1'b0);   // empty: nothing out
   endtask

   // Drain while a write is open; the write goes on at the next address.
   task automatic test_drain_mid_write();
      send_req(REQ_WRITE, 32'h8000_0000, 8'h5A, 1'b0);
      send_req(REQ_WRITE, 32'h0000_0000, 8'hC3, 1'b0);
      send_drain();
      send_req(REQ_WRITE, 32'hDEAD_BEEF, 8'h3C, 1'b1);
      send_drain();
   endtask

   // Size 0 acts as 1: one byte per entry, the ninth byte forces a flush.
   task automatic test_forced_flush();
      set_entry_bytes(4'd0);
      for (int i = 0; i < NUM_ENT + 1; i++)
         send_req(REQ_WRITE, 32'h0000_1000, 8'(i * 17), i == NUM_ENT);
      send_drain();
   endtask

   // Size shrinks while an entry is open and already past the new size.
   task automatic test_size_change();
      set_entry_bytes(4'd15);
      send_req(REQ_WRITE, 32'h0000_2000, 8'h11, 1'b0);
      send_req(REQ_WRITE, 32'h0000_0000, 8'h22, 1'b0);
      send_req(REQ_WRITE, 32'h0000_0000, 8'h33, 1'b0);
      set_entry_bytes(4'd2);
      send_req(REQ_WRITE, 32'h0000_0000, 8'h44, 1'b1);
      send_drain();
   endtask

   // Receiver holds off long while single-byte entries keep arriving:
   // ring fills, a forced flush cannot drain, the input stalls.
   task automatic test_backpressure();
      set_entry_bytes(4'd1);
      sender_gaps_on = 1'b0;
      hold_cycles    = 300;
      for (int i = 0; i < 24; i++)
         send_req(REQ_WRITE, 32'h4000_0000, 8'($urandom), i == 23);
      send_drain();
      sender_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Random traffic: mostly whole writes with random content, plus drains,
   // drains inside a write and raw random items.
   // ------------------------------------------------------------------
   task automatic test_random_traffic(input logic [CSR_W-1:0] size, input int n_items);
      int                sent;
      int                pick;
      int                len;
      int                lim;
      logic [ADDR_W-1:0] addr;
      set_entry_bytes(size);
      lim  = (size == 0) ? 1 : (size > MAX_BYTES) ? MAX_BYTES : int'(size);
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_drain();
            sent++;
         end else if (pick < 22) begin
            send_req(1'($urandom_range(0, 1)), $urandom, 8'($urandom),
                     1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24)
                                                : $urandom_range(1, 2 * lim + 2);
            addr = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                : $urandom;
            for (int i = 0; i < len; i++) begin
               if (i == len / 2 && i != 0 && $urandom_range(0, 9) == 0) begin
                  send_drain();
                  sent++;
               end
               // address only matters on the first byte
               send_req(REQ_WRITE, (i == 0) ? addr : $urandom, 8'($urandom), i == len - 1);
               sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      rsp_hold         = 1'b0;
      hold_cycles      = 0;
      rx_count         = 0;
      rx_mode          = 0;
      errors           = 0;
      items_sent       = 0;
      burst_left       = 0;
      sender_gaps_on   = 1'b1;

      // predictor reset state
      head_idx        = 0;
      tail_idx        = 0;
      used_cnt        = 0;
      next_addr       = '0;
      write_open      = 1'b0;
      entry_bytes_cfg = CSR_ENTRY_BYTES_RESET;
      foreach (ent_fill[i]) ent_fill[i] = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_wrap_and_drain();
      test_drain_mid_write();
      test_forced_flush();
      test_size_change();
      test_backpressure();

      test_random_traffic(4'd1, 80);
      test_random_traffic(4'd8, 80);
      test_random_traffic(4'd0, 60);
      test_random_traffic(4'd15, 80);
      test_random_traffic(4'd3, 80);
      test_random_traffic(4'($urandom_range(0, 15)), 80);

      req_chan.valid <= 1'b0;
      wait (expected_bus_writes.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("byte_write_buffer_fifo: match");
      else
         $display("byte_write_buffer_fifo: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("byte_write_buffer_fifo: mismatch");
      $finish;
   end

endmodule

FILE: byte_write_buffer_fifo.f
src/bwb_pkg.sv
src/bwb_req_if.sv
src/bwb_rsp_if.sv
src/byte_write_buffer_fifo.sv
src/bwb_checker.sv
tb/byte_write_buffer_fifo_tb.sv
